@@ rtl/pph_pkg.sv @@
// Shared types, phase codes and register constants for the parallel printer handshake.
package pph_pkg;

	// Engine phases
	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_WAIT_READY = 3'd1;
	localparam logic [2:0] PH_STROBE     = 3'd2;
	localparam logic [2:0] PH_WAIT_ACK   = 3'd3;
	localparam logic [2:0] PH_RETRY      = 3'd4;

	// Operation codes carried on the input tuser
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SEND = 1'b1;

	// Status pin positions within the sampled status byte
	localparam int ST_NOT_BUSY = 7;
	localparam int ST_ACK_N    = 6;
	localparam int ST_PAPER    = 5;
	localparam int ST_SELECT   = 4;

	// Control pin values: select and init are always high, strobe is bit 0
	localparam logic [4:0] CTL_IDLE   = 5'b01100;
	localparam logic [4:0] CTL_STROBE = 5'b01101;

	// Fault classes
	localparam logic [1:0] FK_NONE   = 2'd0;
	localparam logic [1:0] FK_PAPER  = 2'd1;
	localparam logic [1:0] FK_SELECT = 2'd2;
	localparam logic [1:0] FK_OTHER  = 2'd3;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_TIMEOUT  = 2'd0;
	localparam logic [1:0] REG_STROBE   = 2'd1;
	localparam logic [1:0] REG_RETRY    = 2'd2;
	localparam logic [1:0] REG_BLOCKING = 2'd3;

	// Register reset values
	localparam logic [15:0] TIMEOUT_RST  = 16'h4000;
	localparam logic [7:0]  STROBE_RST   = 8'd2;
	localparam logic [15:0] RETRY_RST    = 16'd500;
	localparam logic        BLOCKING_RST = 1'b1;

	typedef struct packed {
		logic [15:0] timeout_limit;
		logic [7:0]  strobe_ticks;
		logic [15:0] retry_ticks;
		logic        blocking_mode;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [15:0] wait_count;
		logic [7:0]  held_byte;
	} eng_state_t;

	// Packed so that data_lines lands in the lowest bits
	typedef struct packed {
		logic       engine_busy;
		logic [1:0] fault_kind;
		logic       byte_failed;
		logic       byte_done;
		logic       accepted;
		logic [4:0] control_lines;
		logic [7:0] data_lines;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

@@ rtl/pph_step.sv @@
// Next-state and result logic of the handshake engine for one transaction.
module pph_step
	import pph_pkg::*;
(
	input  cfg_t       cfg,
	input  eng_state_t cur,
	input  logic       operation,
	input  logic [7:0] data_byte,
	input  logic [7:0] status_byte,
	output eng_state_t nxt,
	output result_t    res
);

	logic [2:0]  ph;
	logic [15:0] cnt_inc;
	logic [1:0]  fault_class;
	logic        accepted;
	logic        done;
	logic        failed;
	logic [1:0]  kind;

	assign cnt_inc = cur.wait_count + 16'd1;

	always_comb begin
		if (status_byte[ST_PAPER]) begin
			fault_class = FK_PAPER;
		end else if (status_byte[ST_SELECT]) begin
			fault_class = FK_SELECT;
		end else begin
			fault_class = FK_OTHER;
		end
	end

	always_comb begin
		ph       = (cur.phase > PH_RETRY) ? PH_IDLE : cur.phase;
		nxt      = cur;
		nxt.phase = ph;
		accepted = 1'b0;
		done     = 1'b0;
		failed   = 1'b0;
		kind     = FK_NONE;

		if (operation == OP_SEND) begin
			if (ph == PH_IDLE) begin
				nxt.held_byte  = data_byte;
				nxt.phase      = PH_WAIT_READY;
				nxt.wait_count = '0;
				accepted       = 1'b1;
			end
		end else begin
			unique case (ph)
				PH_WAIT_READY: begin
					if (status_byte[ST_NOT_BUSY]) begin
						nxt.phase      = PH_STROBE;
						nxt.wait_count = '0;
					end else begin
						nxt.wait_count = cnt_inc;
						if (cnt_inc >= cfg.timeout_limit) begin
							kind           = fault_class;
							nxt.wait_count = '0;
							nxt.phase      = cfg.blocking_mode ? PH_RETRY : PH_IDLE;
							failed         = ~cfg.blocking_mode;
						end
					end
				end
				PH_STROBE: begin
					nxt.wait_count = cnt_inc;
					if (cnt_inc >= {8'd0, cfg.strobe_ticks}) begin
						nxt.phase      = PH_WAIT_ACK;
						nxt.wait_count = '0;
					end
				end
				PH_WAIT_ACK: begin
					if (!status_byte[ST_ACK_N]) begin
						nxt.phase      = PH_IDLE;
						nxt.wait_count = '0;
						done           = 1'b1;
					end else begin
						nxt.wait_count = cnt_inc;
						if (cnt_inc >= cfg.timeout_limit) begin
							kind           = fault_class;
							nxt.wait_count = '0;
							nxt.phase      = cfg.blocking_mode ? PH_RETRY : PH_IDLE;
							failed         = ~cfg.blocking_mode;
						end
					end
				end
				PH_RETRY: begin
					nxt.wait_count = cnt_inc;
					if (cnt_inc >= cfg.retry_ticks) begin
						nxt.phase      = PH_WAIT_READY;
						nxt.wait_count = '0;
					end
				end
				default: begin
					nxt.phase = ph;
				end
			endcase
		end

		res.data_lines    = nxt.held_byte;
		res.control_lines = (nxt.phase == PH_STROBE) ? CTL_STROBE : CTL_IDLE;
		res.accepted      = accepted;
		res.byte_done     = done;
		res.byte_failed   = failed;
		res.fault_kind    = kind;
		res.engine_busy   = (nxt.phase != PH_IDLE);
	end

endmodule

@@ rtl/parallel_printer_handshake.sv @@
// An input transaction is captured in the stage-one register, and its result in the output register.
// Throughput: one transaction per cycle while the output side does not stall; the engine steps once per item.
// The input register refills in the cycle it hands its item on, so a waiting result stalls
// the input side only once stage one also holds an item.
// Reset (arst_n low, asynchronous): engine idle, wait count and held byte zero, registers at
// their defaults (timeout 16384, strobe 2, retry 500, blocking mode on).
module parallel_printer_handshake
	import pph_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] status_byte
	input  logic        s_tuser,   // [0] operation (0 tick, 1 send)
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] data_lines, [12:8] control_lines, [13] accepted,
	                               // [14] byte_done, [15] byte_failed, [17:16] fault_kind,
	                               // [18] engine_busy, [23:19] zero
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers. Writes must arrive only while no transaction is in flight; the user
	// must ensure this, as the block itself does not enforce it. cfg_ready is tied high.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_limit <= TIMEOUT_RST;
			cfg_q.strobe_ticks  <= STROBE_RST;
			cfg_q.retry_ticks   <= RETRY_RST;
			cfg_q.blocking_mode <= BLOCKING_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIMEOUT:  cfg_q.timeout_limit <= cfg_data;
				REG_STROBE:   cfg_q.strobe_ticks  <= cfg_data[7:0];
				REG_RETRY:    cfg_q.retry_ticks   <= cfg_data;
				REG_BLOCKING: cfg_q.blocking_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Stage one: the accepted input transaction is captured here.
	logic       valid_s1;
	logic       operation_s1;
	logic [7:0] data_byte_s1;
	logic [7:0] status_byte_s1;

	// Result register feeding the output stream.
	logic    out_valid_q;
	result_t result_q;

	// The engine steps whenever stage one holds an item and the result register
	// is free or being emptied in the same cycle.
	logic out_free;
	logic advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			operation_s1   <= s_tuser;
			data_byte_s1   <= s_tdata[7:0];
			status_byte_s1 <= s_tdata[15:8];
		end
	end

	// Engine state: phase, tick counter and the byte being printed.
	eng_state_t eng_q;
	eng_state_t eng_nxt;
	result_t    step_res;

	pph_step u_step (
		.cfg         (cfg_q),
		.cur         (eng_q),
		.operation   (operation_s1),
		.data_byte   (data_byte_s1),
		.status_byte (status_byte_s1),
		.nxt         (eng_nxt),
		.res         (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q.phase      <= PH_IDLE;
			eng_q.wait_count <= '0;
			eng_q.held_byte  <= '0;
		end else if (advance) begin
			eng_q <= eng_nxt;
		end
	end

	// The result of each step is held until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(24 - RESULT_W){1'b0}}, result_q};

endmodule
